// ===== rtl/fmcs_pkg.sv =====
// shared types and constants for the filled circle span generator
package fmcs_pkg;

	localparam int unsigned CoordW  = 10;
	localparam int unsigned RadW    = 4;
	localparam int unsigned ColorW  = 16;
	localparam int unsigned OffW    = 4;
	localparam int unsigned SpanW   = 12;
	localparam int unsigned StepW   = 5;
	localparam int unsigned DecW    = 8;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 56;

	typedef enum logic [1:0] {
		PH_PX_Y = 2'd0,
		PH_MX_Y = 2'd1,
		PH_PY_X = 2'd2,
		PH_MY_X = 2'd3
	} phase_t;

	typedef struct packed {
		logic load;
		logic step;
		logic cfg_we;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last;
	} dp_stat_t;

endpackage

// ===== rtl/fmcs_ctrl.sv =====
// controller state machine: item intake, span sequencing and output valid
module fmcs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	output fmcs_pkg::ctrl_cmd_t cmd,
	input  fmcs_pkg::dp_stat_t  stat
);
	import fmcs_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   valid_q;
	logic   out_free;

	assign out_free   = !valid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign m_tvalid   = valid_q;
	assign cfg_ready  = 1'b1;
	assign cmd.load   = s_tvalid && (state_q == ST_IDLE);
	assign cmd.step   = (state_q == ST_RUN) && out_free;
	assign cmd.cfg_we = cfg_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.step) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/fmcs_dp.sv =====
// datapath: midpoint decision update, span coordinates and output register
module fmcs_dp #(
	parameter int unsigned MAX_RADIUS = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fmcs_pkg::ctrl_cmd_t               cmd,
	output fmcs_pkg::dp_stat_t                stat,
	input  logic [fmcs_pkg::InDataW-1:0]      s_tdata,
	input  logic [fmcs_pkg::OffW-1:0]         cfg_data,
	output logic [fmcs_pkg::OutDataW-1:0]     m_tdata,
	output logic                              m_tlast
);
	import fmcs_pkg::*;

	localparam logic [RadW-1:0] RMax = RadW'(MAX_RADIUS);

	logic [OffW-1:0]          off_q;
	logic [CoordW-1:0]        cx_q, cy_q;
	logic [ColorW-1:0]        color_q;
	logic [StepW-1:0]         x_q, y_q;
	logic signed [DecW-1:0]   d_q;
	phase_t                   phase_q;

	logic [SpanW-1:0]         col_q, top_q, bot_q;
	logic [ColorW-1:0]        ocolor_q;
	logic                     olast_q;

	logic [CoordW-1:0]        in_cx, in_cy;
	logic [RadW-1:0]          in_r, r_sat;
	logic [ColorW-1:0]        in_color;
	logic [StepW-1:0]         a, b, y_next, x_next;
	logic                     neg_col;
	logic signed [DecW-1:0]   d_next, xs, ys;
	logic [SpanW-1:0]         cxo, cyo, col_c, top_c, bot_c;

	assign in_cx    = s_tdata[9:0];
	assign in_cy    = s_tdata[19:10];
	assign in_r     = s_tdata[23:20];
	assign in_color = s_tdata[39:24];
	assign r_sat    = (in_r > RMax) ? RMax : in_r;

	assign xs     = DecW'(x_q);
	assign ys     = DecW'(y_q);
	assign y_next = (d_q < 0) ? y_q : y_q - StepW'(1);
	assign x_next = x_q + StepW'(1);
	assign d_next = (d_q < 0) ? d_q + (xs <<< 1) + DecW'(3)
	                          : d_q + ((xs - ys) <<< 1) + DecW'(5);

	always_comb begin
		case (phase_q)
			PH_PX_Y: begin a = x_q; b = y_q; neg_col = 1'b0; end
			PH_MX_Y: begin a = x_q; b = y_q; neg_col = 1'b1; end
			PH_PY_X: begin a = y_q; b = x_q; neg_col = 1'b0; end
			PH_MY_X: begin a = y_q; b = x_q; neg_col = 1'b1; end
			default: begin a = x_q; b = y_q; neg_col = 1'b0; end
		endcase
	end

	assign cxo   = SpanW'(cx_q) + SpanW'(off_q);
	assign cyo   = SpanW'(cy_q) + SpanW'(off_q);
	assign col_c = neg_col ? cxo - SpanW'(a) : cxo + SpanW'(a);
	assign top_c = cyo - SpanW'(b);
	assign bot_c = cyo + SpanW'(b);

	// loop ends once x passes y; compared before y steps down so y never wraps
	assign stat.last = (phase_q == PH_MY_X)
	                   && ((d_q < 0) ? (x_q >= y_q) : (x_next >= y_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= OffW'(4);
		end else if (cmd.cfg_we) begin
			off_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q    <= in_cx;
			cy_q    <= in_cy;
			color_q <= in_color;
			x_q     <= '0;
			y_q     <= StepW'(r_sat);
			d_q     <= DecW'(1) - DecW'(r_sat);
			phase_q <= PH_PX_Y;
		end else if (cmd.step) begin
			phase_q <= phase_t'(phase_q + 2'd1);
			if (phase_q == PH_MY_X) begin
				x_q <= x_next;
				y_q <= y_next;
				d_q <= d_next;
			end
		end
		if (cmd.step) begin
			col_q    <= col_c;
			top_q    <= top_c;
			bot_q    <= bot_c;
			ocolor_q <= color_q;
			olast_q  <= stat.last;
		end
	end

	assign m_tdata = {4'b0000, ocolor_q, bot_q, top_q, col_q};
	assign m_tlast = olast_q;

endmodule

// ===== rtl/filled_midpoint_circle_spans_top.sv =====
// Filled midpoint circle span generator. One circle request beat yields 4 spans per
// midpoint iteration, one span beat per cycle when the output is not stalled. A request
// is loaded and then stepped once per span, so 44 spans at radius 15 and 4 spans at
// radius 0. The controller takes a new request once the last span of the current circle
// is in the output register; output stalls hold the stepping.
module filled_midpoint_circle_spans_top #(
	parameter int unsigned MAX_RADIUS = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// col_mid[9:0], row_mid[19:10], circle_radius[23:20], paint[39:24]
	input  logic [fmcs_pkg::InDataW-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// span_column[11:0], span_top[23:12], span_bottom[35:24], span_color[51:36]
	output logic [fmcs_pkg::OutDataW-1:0] m_tdata,
	output logic                          m_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fmcs_pkg::OffW-1:0]     cfg_data
);
	import fmcs_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	fmcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	fmcs_dp #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.cfg_data (cfg_data),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/fmcs_checker.sv =====
// port-level checks for the circle span generator, bound to the top level
module fmcs_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [fmcs_pkg::OutDataW-1:0] m_tdata,
	input logic                          m_tlast
);
	import fmcs_pkg::*;

	// stalled beat stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// a circle in progress blocks new requests
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while circle in progress");

	// intake reopens only with the closing span waiting at the output
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> m_tvalid && m_tlast)
		else $error("intake reopened before closing span");

endmodule

bind filled_midpoint_circle_spans_top fmcs_checker u_fmcs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/tb_filled_midpoint_circle_spans_top.sv =====
// testbench for the filled circle span generator: directed and random circles checked against a span predictor
module tb_filled_midpoint_circle_spans_top;
	import fmcs_pkg::*;

	localparam int unsigned MaxRadius  = 15;
	localparam int unsigned MaxSpans   = 48;
	localparam int unsigned CycleLimit = 4000000;
	localparam int unsigned ReportMax  = 10;

	typedef struct packed {
		logic [SpanW-1:0]  column;
		logic [SpanW-1:0]  top;
		logic [SpanW-1:0]  bottom;
		logic [ColorW-1:0] color;
		logic              last;
	} span_t;

	class span_board;
		span_t            spans_due[$];
		logic [OffW-1:0]  offset;
		int unsigned      errors;

		function new();
			offset = OffW'(4);
			errors = 0;
		endfunction

		function int unsigned pending();
			return spans_due.size();
		endfunction

		function void add_span(int col, int row_top, int row_bot, logic [ColorW-1:0] color);
			span_t s;
			s.column = SpanW'(col + int'(offset));
			s.top    = SpanW'(row_top + int'(offset));
			s.bottom = SpanW'(row_bot + int'(offset));
			s.color  = color;
			s.last   = 1'b0;
			spans_due.push_back(s);
		endfunction

		// midpoint iterations, four vertical spans each
		function void note_request(logic [InDataW-1:0] beat);
			int cx, cy, rad, x, y, d, n;
			logic [ColorW-1:0] color;
			cx    = int'(beat[CoordW-1:0]);
			cy    = int'(beat[2*CoordW-1:CoordW]);
			rad   = int'(beat[2*CoordW+RadW-1:2*CoordW]);
			color = beat[2*CoordW+RadW+ColorW-1:2*CoordW+RadW];
			if (rad > int'(MaxRadius)) begin
				rad = MaxRadius;
			end
			x = 0;
			y = rad;
			d = 1 - rad;
			n = 0;
			while (x <= y && n + 4 <= int'(MaxSpans)) begin
				add_span(cx + x, cy - y, cy + y, color);
				add_span(cx - x, cy - y, cy + y, color);
				add_span(cx + y, cy - x, cy + x, color);
				add_span(cx - y, cy - x, cy + x, color);
				n += 4;
				if (d < 0) begin
					d += 2 * x + 3;
				end else begin
					d += 2 * (x - y) + 5;
					y--;
				end
				x++;
			end
			spans_due[spans_due.size() - 1].last = 1'b1;
		endfunction

		function void check_span(logic [OutDataW-1:0] data, logic last);
			span_t got, want;
			got.column = data[SpanW-1:0];
			got.top    = data[2*SpanW-1:SpanW];
			got.bottom = data[3*SpanW-1:2*SpanW];
			got.color  = data[3*SpanW+ColorW-1:3*SpanW];
			got.last   = last;
			if (spans_due.size() == 0) begin
				errors++;
				if (errors <= ReportMax) begin
					$display("span beat with no circle pending: col %0d top %0d bot %0d color %h last %b",
						$signed(got.column), $signed(got.top), $signed(got.bottom), got.color, got.last);
				end
				return;
			end
			want = spans_due.pop_front();
			if (got.column !== want.column || got.top !== want.top || got.bottom !== want.bottom
					|| got.color !== want.color || got.last !== want.last) begin
				errors++;
				if (errors <= ReportMax) begin
					$display("span mismatch: expected col %0d top %0d bot %0d color %h last %b",
						$signed(want.column), $signed(want.top), $signed(want.bottom), want.color,
						want.last);
					$display("                    got col %0d top %0d bot %0d color %h last %b",
						$signed(got.column), $signed(got.top), $signed(got.bottom), got.color,
						got.last);
				end
			end
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [InDataW-1:0]   s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [OutDataW-1:0]  m_tdata;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [OffW-1:0]      cfg_data  = '0;

	span_board   board;
	bit          no_gaps;
	int unsigned hold_request;
	int unsigned cycles;

	filled_midpoint_circle_spans_top #(
		.MAX_RADIUS(MaxRadius)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d spans still expected", cycles, board.pending());
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_span(m_tdata, m_tlast);
		end
	end

	function automatic int unsigned idle_len();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 60);
		end
		return $urandom_range(1, 3);
	endfunction

	// output side: random stalls plus one long hold-off on request
	initial begin : span_sink
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!no_gaps && $urandom_range(0, 99) < 30) begin
				stall_left = idle_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [InDataW-1:0] pack_circle(int unsigned cx, int unsigned cy,
			int unsigned rad, int unsigned color);
		return {ColorW'(color), RadW'(rad), CoordW'(cy), CoordW'(cx)};
	endfunction

	function automatic logic [InDataW-1:0] random_circle();
		int unsigned cx, cy, rad, pick;
		pick = $urandom_range(0, 99);
		rad = (pick < 20) ? MaxRadius : (pick < 30) ? 0 : $urandom_range(0, MaxRadius);
		cx = $urandom_range(0, 1023);
		cy = $urandom_range(0, 1023);
		if ($urandom_range(0, 6) == 0) begin
			cx = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(1008, 1023);
		end
		if ($urandom_range(0, 6) == 0) begin
			cy = $urandom_range(0, 1) ? $urandom_range(0, 15) : $urandom_range(1008, 1023);
		end
		return pack_circle(cx, cy, rad, $urandom_range(0, 65535));
	endfunction

	task automatic offer_circle(input logic [InDataW-1:0] beat);
		s_tdata  <= beat;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_request(beat);
	endtask

	task automatic idle_sender(input int unsigned n);
		s_tvalid <= 1'b0;
		s_tdata  <= InDataW'({$urandom(), $urandom()});
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_offset(input logic [OffW-1:0] value);
		drain();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.offset = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				no_gaps = ($urandom_range(0, 3) == 0);
			end
			offer_circle(random_circle());
			if (!no_gaps && $urandom_range(0, 99) < 40) begin
				idle_sender(idle_len());
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		board = new();
		no_gaps = 1'b0;
		hold_request = 0;
		cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset offset first, then extremes
		offer_circle(pack_circle(512, 512, 0, 16'h0000));
		offer_circle(pack_circle(512, 512, 1, 16'hffff));
		write_offset(OffW'(0));
		offer_circle(pack_circle(0, 0, 15, 16'hf800));
		offer_circle(pack_circle(1023, 1023, 15, 16'h07e0));
		offer_circle(pack_circle(0, 1023, 7, 16'h001f));
		offer_circle(pack_circle(1023, 0, 8, 16'h5555));
		for (int unsigned r = 2; r < MaxRadius; r++) begin
			offer_circle(pack_circle(100 + r * 50, 900 - r * 40, r, (r % 2) ? 16'haaaa : 16'h5555));
			if (r % 3 == 0) begin
				idle_sender(idle_len());
			end
		end

		write_offset(OffW'(15));
		run_random(110);

		// long output hold while requests keep coming
		write_offset(OffW'($urandom_range(1, 14)));
		hold_request = 300;
		for (int unsigned i = 0; i < 12; i++) begin
			offer_circle(pack_circle($urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(10, 15), $urandom_range(0, 65535)));
		end
		drain();
		run_random(100);

		write_offset(OffW'(4));
		run_random(100);

		drain();
		repeat (60) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches, %0d spans still expected", board.errors, board.pending());
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
